### sv/box_filter_zero_pad_core_macros.svh
// Assertion macros shared by the box filter RTL
`ifndef BOX_FILTER_ZERO_PAD_CORE_MACROS_SVH
`define BOX_FILTER_ZERO_PAD_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BFZP_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define BFZP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/bfzp_pkg.sv
// Constants, types and the reciprocal table of the box filter
`timescale 1ns / 1ps

package bfzp_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int MAX_RADIUS  = 3;
	localparam int KSIDE       = 2 * MAX_RADIUS + 1;
	localparam int LINES       = 2 * MAX_RADIUS;
	localparam int PIX_W       = 8;
	localparam int LINE_BITS   = LINES * PIX_W;
	localparam int DIM_W       = 11;
	localparam int RAD_W       = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT + 2 * KSIDE);
	localparam int LAG_W       = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
	localparam int CSUM_W      = $clog2(KSIDE * 255 + 1);
	localparam int WSUM_W      = $clog2(KSIDE * KSIDE * 255 + 1);
	localparam int RECIP_W     = 21;
	localparam int RECIP_SHIFT = 20;

	localparam logic [RAD_W-1:0] RADIUS_RST = 2'd1;
	localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RADIUS = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2
	} cfg_reg_t;

	// clamped frame geometry
	typedef struct packed {
		logic [RAD_W-1:0] radius;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} geom_t;

	// pixel request into the line store
	typedef struct packed {
		logic             valid;
		logic [PIX_W-1:0] pix;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} px_req_t;

	// output bookkeeping that rides along with a request
	typedef struct packed {
		logic             valid;
		logic             emit;
		logic [COL_W-1:0] ocol;
		logic             last;
	} out_tag_t;

	typedef struct packed {
		logic             valid;
		logic [PIX_W-1:0] pixel;
		logic             last;
	} result_t;

	// ceil(2^20 / (2r+1)^2)
	function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] r);
		logic [RECIP_W-1:0] v;
		case (r)
			2'd0:    v = 21'd1048576;
			2'd1:    v = 21'd116509;
			2'd2:    v = 21'd41944;
			default: v = 21'd21400;
		endcase
		return v;
	endfunction

endpackage

### sv/bfzp_colsum.sv
// Line store with column history and vertical column sum
`timescale 1ns / 1ps

module bfzp_colsum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  bfzp_pkg::px_req_t             req,
	input  bfzp_pkg::geom_t               geom,
	output logic [bfzp_pkg::CSUM_W-1:0]   csum
);

	// one entry per column: pixels of the last rows, newest in the low byte
	logic [bfzp_pkg::LINE_BITS-1:0] mem [bfzp_pkg::MAX_WIDTH];
	logic [bfzp_pkg::LINE_BITS-1:0] rd_q;
	logic [bfzp_pkg::LINE_BITS-1:0] fwd_data_s1;
	logic [bfzp_pkg::LINE_BITS-1:0] hist;
	logic [bfzp_pkg::LINE_BITS-1:0] wr_data;
	bfzp_pkg::px_req_t              req_s1;
	logic                           fwd_s1;
	logic                           wr_en;

	always_comb begin
		hist    = fwd_s1 ? fwd_data_s1 : rd_q;
		wr_data = {hist[bfzp_pkg::LINE_BITS-bfzp_pkg::PIX_W-1:0], req_s1.pix};
		wr_en   = adv && req_s1.valid;
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			rd_q <= mem[req.col];
		end
		if (wr_en) begin
			mem[req_s1.col] <= wr_data;
		end
	end

	// a one-pixel-wide frame reads the column that is being written back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
			fwd_s1 <= 1'b0;
		end else if (adv) begin
			req_s1 <= req;
			fwd_s1 <= req.valid && wr_en && (req.col == req_s1.col);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_data_s1 <= wr_data;
		end
	end

	// history slot k holds row (row - 1 - k); drop rows above the frame or below it
	always_comb begin
		csum = bfzp_pkg::CSUM_W'(req_s1.pix);
		for (int k = 0; k < bfzp_pkg::LINES; k++) begin
			if (((bfzp_pkg::RAD_W + 1)'(k) < {geom.radius, 1'b0})
			    && ((bfzp_pkg::ROW_W + 1)'(req_s1.row) > (bfzp_pkg::ROW_W + 1)'(k))
			    && ((bfzp_pkg::ROW_W + 1)'(req_s1.row)
			        <= (bfzp_pkg::ROW_W + 1)'(geom.height) + (bfzp_pkg::ROW_W + 1)'(k))) begin
				csum = csum + bfzp_pkg::CSUM_W'(hist[k*bfzp_pkg::PIX_W +: bfzp_pkg::PIX_W]);
			end
		end
	end

endmodule

### sv/bfzp_window.sv
// Horizontal window of column sums and reciprocal scaling
`timescale 1ns / 1ps

module bfzp_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [bfzp_pkg::CSUM_W-1:0]   csum,
	input  bfzp_pkg::out_tag_t            tag,
	input  bfzp_pkg::geom_t               geom,
	output bfzp_pkg::result_t             res
);

	logic [bfzp_pkg::CSUM_W-1:0]                   hs_q [bfzp_pkg::KSIDE];
	bfzp_pkg::out_tag_t                            tag_s2;
	bfzp_pkg::out_tag_t                            tag_s3;
	logic [bfzp_pkg::WSUM_W-1:0]                   wsum;
	logic [bfzp_pkg::WSUM_W-1:0]                   sum_s3;
	logic [bfzp_pkg::DIM_W:0]                      base;
	logic [bfzp_pkg::DIM_W:0]                      hi;
	logic [bfzp_pkg::WSUM_W+bfzp_pkg::RECIP_W-1:0] prod;

	// advance only on real positions so tap k is always k positions back
	always_ff @(posedge clk) begin
		if (adv && tag.valid) begin
			hs_q[0] <= csum;
			for (int k = 1; k < bfzp_pkg::KSIDE; k++) begin
				hs_q[k] <= hs_q[k-1];
			end
		end
	end

	// tap k sits at column ocol + radius - k; keep it only inside the row
	always_comb begin
		base = (bfzp_pkg::DIM_W + 1)'(tag_s2.ocol) + (bfzp_pkg::DIM_W + 1)'(geom.radius);
		hi   = (bfzp_pkg::DIM_W + 1)'(geom.width) - (bfzp_pkg::DIM_W + 1)'(1);
		wsum = '0;
		for (int k = 0; k < bfzp_pkg::KSIDE; k++) begin
			if (((bfzp_pkg::RAD_W + 1)'(k) <= {geom.radius, 1'b0})
			    && (base >= (bfzp_pkg::DIM_W + 1)'(k))
			    && (base <= hi + (bfzp_pkg::DIM_W + 1)'(k))) begin
				wsum = wsum + bfzp_pkg::WSUM_W'(hs_q[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (adv) begin
			tag_s2 <= tag;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= wsum;
		end
	end

	always_comb begin
		prod      = sum_s3 * bfzp_pkg::recip(geom.radius);
		res.valid = tag_s3.valid && tag_s3.emit;
		res.pixel = prod[bfzp_pkg::RECIP_SHIFT +: bfzp_pkg::PIX_W];
		res.last  = tag_s3.last;
	end

endmodule

### sv/box_filter_zero_pad_core.sv
// Top level of the streaming zero-padded box filter
// Usage:
//   Pixels enter in raster order on s_axis, one request per clock unless stalled.
//   tuser set marks a flush request: the position advances with no pixel.
//   Each request carrying position k + R*W + R yields output k on m_axis; earlier
//   requests of a frame yield nothing. tlast marks the frame's final output, after
//   which the next request starts a new frame. Send R*W + R flush requests after
//   the last pixel to drain a frame.
//   Path: a taken request's result passes the s1, s2, s3 and output registers.
//   Throughput: one request per clock unless stalled, set by the single read-modify-write
//   of one column entry of the line memory per request (6 rows x 1024 columns x 8 bits).
//   Reset: position counters clear, radius/width/height return to 1/640/480; the
//   line memory is not cleared and has no clearing pass, since rows of a new frame
//   are masked out until written.
//   Stall: an output register plus one skid entry; s_axis_tready drops only while
//   the skid entry is full. Write cfg only with the pipeline empty; a write to any
//   register restarts the frame.
`timescale 1ns / 1ps
`include "box_filter_zero_pad_core_macros.svh"

module box_filter_zero_pad_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [bfzp_pkg::PIX_W-1:0]       s_axis_tdata,  // [7:0] pixel_in
	input  logic                             s_axis_tuser,  // [0] action
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [bfzp_pkg::PIX_W-1:0]       m_axis_tdata,  // [7:0] pixel_out
	output logic                             m_axis_tlast,
	input  logic                             cfg_we,
	input  logic [bfzp_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bfzp_pkg::DIM_W-1:0]       cfg_data
);

	logic [bfzp_pkg::RAD_W-1:0] radius_q;
	logic [bfzp_pkg::DIM_W-1:0] width_q;
	logic [bfzp_pkg::DIM_W-1:0] height_q;
	bfzp_pkg::geom_t            geom;
	logic [bfzp_pkg::LAG_W-1:0] lag;
	logic [bfzp_pkg::LAG_W-1:0] lag_w;

	logic [bfzp_pkg::COL_W-1:0] pc_q;
	logic [bfzp_pkg::ROW_W-1:0] pr_q;
	logic [bfzp_pkg::COL_W-1:0] ocol_q;
	logic [bfzp_pkg::COL_W-1:0] orow_q;
	logic [bfzp_pkg::LAG_W-1:0] lead_q;

	logic                       adv;
	logic                       accept;
	logic                       cfg_hit;
	logic                       emit_s0;
	logic                       last_s0;
	logic [bfzp_pkg::PIX_W-1:0] pix_s0;
	bfzp_pkg::px_req_t          req_s0;
	bfzp_pkg::out_tag_t         tag_s1;
	logic [bfzp_pkg::CSUM_W-1:0] csum_s1;
	bfzp_pkg::result_t          res_s3;
	logic                       push;

	logic                       out_valid_q;
	logic [bfzp_pkg::PIX_W-1:0] out_pix_q;
	logic                       out_last_q;
	logic                       skid_valid_q;
	logic [bfzp_pkg::PIX_W-1:0] skid_pix_q;
	logic                       skid_last_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= bfzp_pkg::RADIUS_RST;
			width_q  <= bfzp_pkg::WIDTH_RST;
			height_q <= bfzp_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				bfzp_pkg::CFG_RADIUS: radius_q <= cfg_data[bfzp_pkg::RAD_W-1:0];
				bfzp_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				bfzp_pkg::CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_hit = cfg_we && (cfg_idx == bfzp_pkg::CFG_RADIUS
	                            || cfg_idx == bfzp_pkg::CFG_WIDTH
	                            || cfg_idx == bfzp_pkg::CFG_HEIGHT);

	// zero reads as one, oversize saturates
	always_comb begin
		geom.radius = radius_q;
		if (width_q == '0) begin
			geom.width = bfzp_pkg::DIM_W'(1);
		end else if (width_q > bfzp_pkg::DIM_W'(bfzp_pkg::MAX_WIDTH)) begin
			geom.width = bfzp_pkg::DIM_W'(bfzp_pkg::MAX_WIDTH);
		end else begin
			geom.width = width_q;
		end
		if (height_q == '0) begin
			geom.height = bfzp_pkg::DIM_W'(1);
		end else if (height_q > bfzp_pkg::DIM_W'(bfzp_pkg::MAX_HEIGHT)) begin
			geom.height = bfzp_pkg::DIM_W'(bfzp_pkg::MAX_HEIGHT);
		end else begin
			geom.height = height_q;
		end
	end

	// lag = R*W + R
	always_comb begin
		lag_w = bfzp_pkg::LAG_W'(geom.width);
		case (geom.radius)
			2'd0:    lag = '0;
			2'd1:    lag = lag_w + bfzp_pkg::LAG_W'(1);
			2'd2:    lag = (lag_w << 1) + bfzp_pkg::LAG_W'(2);
			default: lag = (lag_w << 1) + lag_w + bfzp_pkg::LAG_W'(3);
		endcase
	end

	assign adv           = !skid_valid_q;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;

	always_comb begin
		emit_s0 = (lead_q == lag);
		last_s0 = emit_s0
		          && (bfzp_pkg::DIM_W'(orow_q) == geom.height - bfzp_pkg::DIM_W'(1))
		          && (bfzp_pkg::DIM_W'(ocol_q) == geom.width - bfzp_pkg::DIM_W'(1));
		// flush requests and anything past the frame's last row enter as zero
		pix_s0 = (!s_axis_tuser && (pr_q < geom.height)) ? s_axis_tdata : '0;
		req_s0.valid = accept;
		req_s0.pix   = pix_s0;
		req_s0.row   = pr_q;
		req_s0.col   = pc_q;
	end

	// input and output raster positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			pr_q   <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			lead_q <= '0;
		end else if (cfg_hit || (accept && last_s0)) begin
			pc_q   <= '0;
			pr_q   <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			lead_q <= '0;
		end else if (accept) begin
			if (bfzp_pkg::DIM_W'(pc_q) == geom.width - bfzp_pkg::DIM_W'(1)) begin
				pc_q <= '0;
				pr_q <= pr_q + bfzp_pkg::ROW_W'(1);
			end else begin
				pc_q <= pc_q + bfzp_pkg::COL_W'(1);
			end
			if (emit_s0) begin
				if (bfzp_pkg::DIM_W'(ocol_q) == geom.width - bfzp_pkg::DIM_W'(1)) begin
					ocol_q <= '0;
					orow_q <= orow_q + bfzp_pkg::COL_W'(1);
				end else begin
					ocol_q <= ocol_q + bfzp_pkg::COL_W'(1);
				end
			end else begin
				lead_q <= lead_q + bfzp_pkg::LAG_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1.valid <= accept;
			tag_s1.emit  <= emit_s0;
			tag_s1.ocol  <= ocol_q;
			tag_s1.last  <= last_s0;
		end
	end

	bfzp_colsum u_colsum (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.req    (req_s0),
		.geom   (geom),
		.csum   (csum_s1)
	);

	bfzp_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.csum   (csum_s1),
		.tag    (tag_s1),
		.geom   (geom),
		.res    (res_s3)
	);

	// output register with one skid entry
	assign push = adv && res_s3.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_axis_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_axis_tready) begin
				out_pix_q  <= skid_pix_q;
				out_last_q <= skid_last_q;
			end
		end else if (!out_valid_q || m_axis_tready) begin
			if (push) begin
				out_pix_q  <= res_s3.pixel;
				out_last_q <= res_s3.last;
			end
		end else if (push) begin
			skid_pix_q  <= res_s3.pixel;
			skid_last_q <= res_s3.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_pix_q;
	assign m_axis_tlast  = out_last_q;

	`BFZP_ASSERT_HOLDS(a_skid_behind_out, skid_valid_q, out_valid_q, "skid entry full while output register empty")
	`BFZP_ASSERT_NEXT(a_frame_restart, accept && last_s0 && !cfg_hit, (pc_q == '0) && (pr_q == '0) && (lead_q == '0), "frame end did not restart positions")
	`BFZP_ASSERT_HOLDS(a_col_in_row, 1'b1, (bfzp_pkg::DIM_W'(pc_q) < geom.width) && (bfzp_pkg::DIM_W'(ocol_q) < geom.width), "column counter beyond frame width")

endmodule
